[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL. Every check is sampled on the rising edge of clk_i.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property while the block is out of reset.
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property at every edge, reset included.
`define JSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

[hw/rtl/jse_pkg.sv]
`timescale 1ns / 1ps

package jse_pkg;

  localparam int MaxElements = 1024;
  localparam int DataW       = 32;
  localparam int IdxW        = 10;
  localparam int SizeW       = 11;
  // Search counters run a little past the largest array size.
  localparam int CntW        = 12;
  // floor(sqrt(2047)) is 45.
  localparam int RootW       = 6;

  localparam logic OpWrite  = 1'b0;
  localparam logic OpSearch = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQRT,
    ST_JUMP,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

[hw/rtl/jse_item_if.sv]
`timescale 1ns / 1ps

interface jse_item_if;
  logic                              valid;
  logic                              ready;
  logic                              operation;
  logic [jse_pkg::IdxW-1:0]          write_index;
  logic signed [jse_pkg::DataW-1:0]  element_value;
  logic signed [jse_pkg::DataW-1:0]  search_key;

  modport source (output valid, output operation, output write_index,
                  output element_value, output search_key, input ready);
  modport sink (input valid, input operation, input write_index,
                input element_value, input search_key, output ready);
endinterface

[hw/rtl/jse_result_if.sv]
`timescale 1ns / 1ps

interface jse_result_if;
  logic                     valid;
  logic                     ready;
  logic                     found;
  logic [jse_pkg::IdxW-1:0] position;

  modport source (output valid, output found, output position, input ready);
  modport sink (input valid, input found, input position, output ready);
endinterface

[hw/rtl/jse_store.sv]
`timescale 1ns / 1ps

// Element store: one write port, one read port, read data registered.
module jse_store #(
  parameter int Depth = jse_pkg::MaxElements,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [AddrW-1:0]                 waddr_i,
  input  logic signed [jse_pkg::DataW-1:0] wdata_i,
  input  logic                             re_i,
  input  logic [AddrW-1:0]                 raddr_i,
  output logic signed [jse_pkg::DataW-1:0] rdata_o
);

  logic signed [jse_pkg::DataW-1:0] mem_q [Depth];
  logic signed [jse_pkg::DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/jse_isqrt.sv]
`timescale 1ns / 1ps

// Integer square root, one result bit per cycle from the top down.
module jse_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [jse_pkg::SizeW-1:0]   value_i,
  output logic                        done_o,
  output logic [jse_pkg::RootW-1:0]   root_o
);

  localparam int BitW = $clog2(jse_pkg::RootW);

  logic                          busy_q;
  logic                          done_q;
  logic [BitW-1:0]               bit_q;
  logic [jse_pkg::RootW-1:0]     root_q;
  logic [jse_pkg::SizeW-1:0]     val_q;
  logic [jse_pkg::RootW-1:0]     trial;
  logic [2*jse_pkg::RootW-1:0]   square;
  logic                          fits;

  assign trial  = root_q | (jse_pkg::RootW'(1) << bit_q);
  assign square = (2*jse_pkg::RootW)'(trial) * (2*jse_pkg::RootW)'(trial);
  assign fits   = square <= (2*jse_pkg::RootW)'(val_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= busy_q && (bit_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= BitW'(jse_pkg::RootW - 1);
      end else if (busy_q) begin
        if (bit_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          bit_q <= bit_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      root_q <= '0;
      val_q  <= value_i;
    end else if (busy_q && fits) begin
      root_q <= trial;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

[hw/rtl/jump_search_engine.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Jump search engine. A write transfer (operation 0) stores element_value at write_index in an
// element store with one write port and one read port; it yields no result. A search transfer
// (operation 1) looks for search_key in the first array_size entries, which must be sorted in
// ascending signed order and must all have been written, and yields one result transfer with
// found and position (position is 0 when the key is absent). A search is accepted, then a
// bit-serial root unit forms the block length floor(sqrt(n)), the first probe is issued once
// the root is known, and the store is read once per block probed and once per entry scanned;
// finally the output register is loaded once it is free. The one read port of the store sets
// the pace. When n is 0 the root unit and the probes are skipped. One item is processed at a
// time, but a finished result waits in the output register while the next item is accepted.
// array_size is written through cfg_we_i and cfg_data_i; the user writes it only while the
// block is idle, a rule that the block itself leaves unchecked. Values above MAX_ELEMENTS are
// treated as MAX_ELEMENTS.
module jump_search_engine #(
  parameter int MAX_ELEMENTS = jse_pkg::MaxElements
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [jse_pkg::SizeW-1:0]  cfg_data_i,
  jse_item_if.sink                   item_i,
  jse_result_if.source               result_o
);

  localparam int AddrW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CntW  = jse_pkg::CntW;
  // Largest usable array length: the register range or the store depth.
  localparam logic [CntW-1:0] MaxCnt =
      (MAX_ELEMENTS > (2**jse_pkg::SizeW - 1)) ? CntW'(2**jse_pkg::SizeW - 1)
                                                : CntW'(MAX_ELEMENTS);

  jse_pkg::state_e state_q, state_d;

  logic [jse_pkg::SizeW-1:0]        size_q;
  logic signed [jse_pkg::DataW-1:0] key_q, key_d;
  logic [CntW-1:0]                  n_q, n_d;
  logic [CntW-1:0]                  jump_q, jump_d;
  logic [CntW-1:0]                  blk_q, blk_d;
  logic [CntW-1:0]                  lo_q, lo_d;
  logic                             found_q, found_d;
  logic [jse_pkg::IdxW-1:0]         pos_q, pos_d;

  logic                             out_valid_q;
  logic                             out_found_q;
  logic [jse_pkg::IdxW-1:0]         out_pos_q;
  logic                             out_load;

  logic                             accept;
  logic                             mem_we;
  logic                             rd_en;
  logic [CntW-1:0]                  rd_addr;
  logic signed [jse_pkg::DataW-1:0] rd_data;

  logic                             sqrt_start;
  logic                             sqrt_done;
  logic [jse_pkg::RootW-1:0]        root;

  logic [CntW-1:0]                  n_in;
  logic [CntW-1:0]                  root_ext;
  logic [CntW-1:0]                  first_cap;
  logic [CntW-1:0]                  blk_cap;
  logic [CntW-1:0]                  blk_next;
  logic [CntW-1:0]                  next_cap;
  logic [CntW-1:0]                  lo_inc;
  logic                             below;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
    end
  end

  assign accept = item_i.valid && item_i.ready;

  // Writes go straight to the store on the accepting edge; entries past the store are dropped.
  assign mem_we = accept && (item_i.operation == jse_pkg::OpWrite) &&
                  (int'(item_i.write_index) < MAX_ELEMENTS);

  jse_store #(
    .Depth (MAX_ELEMENTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AddrW'(item_i.write_index)),
    .wdata_i (item_i.element_value),
    .re_i    (rd_en),
    .raddr_i (AddrW'(rd_addr)),
    .rdata_o (rd_data)
  );

  jse_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (jse_pkg::SizeW'(n_in)),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Address arithmetic. Block ends are capped at n, so every read stays below n.
  assign n_in      = (CntW'(size_q) > MaxCnt) ? MaxCnt : CntW'(size_q);
  assign root_ext  = CntW'(root);
  assign first_cap = (root_ext < n_q) ? root_ext : n_q;
  assign blk_cap   = (blk_q < n_q) ? blk_q : n_q;
  assign blk_next  = blk_q + jump_q;
  assign next_cap  = (blk_next < n_q) ? blk_next : n_q;
  assign lo_inc    = lo_q + 1'b1;
  assign below     = rd_data < key_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jse_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    n_q     <= n_d;
    jump_q  <= jump_d;
    blk_q   <= blk_d;
    lo_q    <= lo_d;
    found_q <= found_d;
    pos_q   <= pos_d;
  end

  // Search sequencer. While probing, the read for the next step is issued in the same
  // cycle as the compare on the data just returned, so the store is read every cycle.
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    n_d         = n_q;
    jump_d      = jump_q;
    blk_d       = blk_q;
    lo_d        = lo_q;
    found_d     = found_q;
    pos_d       = pos_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    sqrt_start  = 1'b0;
    out_load    = 1'b0;
    item_i.ready = 1'b0;

    case (state_q)
      jse_pkg::ST_IDLE: begin
        item_i.ready = 1'b1;
        if (item_i.valid && (item_i.operation == jse_pkg::OpSearch)) begin
          key_d = item_i.search_key;
          n_d   = n_in;
          if (n_in == '0) begin
            found_d = 1'b0;
            pos_d   = '0;
            state_d = jse_pkg::ST_DONE;
          end else begin
            // The root unit takes n on the accepting edge.
            sqrt_start = 1'b1;
            state_d    = jse_pkg::ST_SQRT;
          end
        end
      end

      jse_pkg::ST_SQRT: begin
        // Once the root is ready, the first block end is probed.
        if (sqrt_done) begin
          jump_d  = root_ext;
          blk_d   = root_ext;
          lo_d    = '0;
          rd_en   = 1'b1;
          rd_addr = first_cap - 1'b1;
          state_d = jse_pkg::ST_JUMP;
        end
      end

      jse_pkg::ST_JUMP: begin
        if (below) begin
          lo_d  = blk_q;
          blk_d = blk_next;
          if (blk_q >= n_q) begin
            found_d = 1'b0;
            pos_d   = '0;
            state_d = jse_pkg::ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = next_cap - 1'b1;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = lo_q;
          state_d = jse_pkg::ST_SCAN;
        end
      end

      jse_pkg::ST_SCAN: begin
        if (below) begin
          lo_d = lo_inc;
          if (lo_inc == blk_cap) begin
            found_d = 1'b0;
            pos_d   = '0;
            state_d = jse_pkg::ST_DONE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = lo_inc;
          end
        end else begin
          found_d = (rd_data == key_q);
          pos_d   = (rd_data == key_q) ? jse_pkg::IdxW'(lo_q) : '0;
          state_d = jse_pkg::ST_DONE;
        end
      end

      jse_pkg::ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          out_load = 1'b1;
          state_d  = jse_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = jse_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: a finished result waits here while the next item is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_found_q <= found_q;
      out_pos_q   <= pos_q;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.found    = out_found_q;
  assign result_o.position = out_pos_q;

  `JSE_ASSERT(a_read_in_range, ((state_q == jse_pkg::ST_JUMP) || (state_q == jse_pkg::ST_SCAN)) |-> (lo_q < n_q), "search index ran past the array")
  `JSE_ASSERT(a_jump_nonzero, (state_q == jse_pkg::ST_JUMP) |-> (jump_q != '0), "block length is zero during the jump phase")
  `JSE_ASSERT(a_root_done_in_sqrt, sqrt_done |-> (state_q == jse_pkg::ST_SQRT), "root unit finished outside the root phase")
  `JSE_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == jse_pkg::ST_DONE), "result raised without a finished search")
  `JSE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> (state_q == jse_pkg::ST_IDLE), "sequencer not idle after reset")

endmodule

[test/search_result_checker.sv]
`timescale 1ns / 1ps

// Watches the item and result channels of the jump search engine. It keeps its own copy of
// the element store and of array_size, works out the result of every search that is
// transferred, and compares each result transfer with the oldest expectation.
module search_result_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [jse_pkg::SizeW-1:0] cfg_data_i,
  jse_item_if                       item_i,
  jse_result_if                     result_i,
  output int                        mismatches_o,
  output int                        outstanding_o
);

  typedef struct packed {
    logic signed [jse_pkg::DataW-1:0] key;
    logic                             found;
    logic [jse_pkg::IdxW-1:0]         position;
  } lookup_t;

  logic signed [jse_pkg::DataW-1:0] mirror_store [jse_pkg::MaxElements];
  logic [jse_pkg::SizeW-1:0]        size_q;
  lookup_t                          expected_lookups [$];

  function automatic lookup_t predict_lookup(input logic signed [jse_pkg::DataW-1:0] key);
    lookup_t r;
    int      n;
    int      stride;
    int      blk_end;
    int      lo;
    r          = '0;
    r.key      = key;
    n          = (size_q > jse_pkg::MaxElements) ? jse_pkg::MaxElements : int'(size_q);
    if (n == 0) return r;
    stride = 0;
    while ((stride + 1) * (stride + 1) <= n) stride++;
    blk_end = stride;
    lo      = 0;
    while (mirror_store[((blk_end < n) ? blk_end : n) - 1] < key) begin
      lo      = blk_end;
      blk_end = blk_end + stride;
      if (lo >= n) return r;
    end
    while (mirror_store[lo] < key) begin
      lo++;
      if (lo == ((blk_end < n) ? blk_end : n)) return r;
    end
    if (mirror_store[lo] == key) begin
      r.found    = 1'b1;
      r.position = lo[jse_pkg::IdxW-1:0];
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("%0t: search result mismatch: %s", $time, what);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_t want;
    int      delta;
    if (!rst_ni) begin
      size_q        <= '0;
      outstanding_o <= 0;
      mismatches_o  = 0;
      expected_lookups.delete();
    end else begin
      delta = 0;
      if (cfg_we_i) size_q <= cfg_data_i;
      // Results are taken before new searches so a result never meets its own search.
      if (result_i.valid && result_i.ready) begin
        if (expected_lookups.size() == 0) begin
          flag_mismatch($sformatf("result found=%b position=%0d with no search outstanding",
                                  result_i.found, result_i.position));
        end else begin
          want  = expected_lookups.pop_front();
          delta = delta - 1;
          if (result_i.found !== want.found)
            flag_mismatch($sformatf("key %0d: found %b, expected %b",
                                    want.key, result_i.found, want.found));
          if (result_i.position !== want.position)
            flag_mismatch($sformatf("key %0d: position %0d, expected %0d",
                                    want.key, result_i.position, want.position));
        end
      end
      if (item_i.valid && item_i.ready) begin
        if (item_i.operation == jse_pkg::OpWrite) begin
          mirror_store[item_i.write_index] = item_i.element_value;
        end else begin
          expected_lookups.push_back(predict_lookup(item_i.search_key));
          delta = delta + 1;
        end
      end
      outstanding_o <= outstanding_o + delta;
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

// Testbench for the jump search engine.
//
// The top only makes stimulus and gives the verdict; the checker beside the block watches
// both channels, predicts every search and counts mismatches.
//
// Stimulus runs in stages. A short directed stage covers the empty array, a single element,
// the two extremes of the signed range as both elements and keys, a key beyond the last
// element, duplicates and the top store index. A second stage fills the whole store with a
// sorted array and searches it at full size and at sizes above capacity, which the block
// saturates. The random stage then goes through phases, each of which sets array_size,
// loads a fresh array of that length if it is nonzero and fits the store (mostly sorted,
// sometimes clustered so that duplicates appear, now and then unsorted) and searches it with
// keys that are mostly present, with neighbours of present values, extremes and random keys.
//
// array_size is only written once the block is idle: every outstanding search has come back
// and a few cycles have passed for a trailing write transfer. No search ever reaches a store
// entry that has not been written, since each phase loads entries 0 to n-1 first and the
// sizes above capacity are used only after the whole store has been loaded.
//
// The sender works in bursts with random gaps and sometimes waits until every result has
// come back; the receiver stalls on a pattern that it picks anew for each random stretch.
module tb;

  localparam int CycleLimit    = 800000;
  // Wait that lets a trailing write transfer finish before array_size is written.
  localparam int WriteSettle   = 4;
  // Final wait after the last result, meant to cover a full-size search.
  localparam int SearchLatency = 80;
  // Items over all stages; the full store load alone takes 1024 of them.
  localparam int TotalItems    = 1200;

  localparam logic signed [jse_pkg::DataW-1:0] KeyMin = {1'b1, {(jse_pkg::DataW-1){1'b0}}};
  localparam logic signed [jse_pkg::DataW-1:0] KeyMax = {1'b0, {(jse_pkg::DataW-1){1'b1}}};

  typedef enum logic [1:0] {
    FillSpread,
    FillClustered,
    FillShuffled
  } fill_e;

  logic                      clk_i  = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we;
  logic [jse_pkg::SizeW-1:0] cfg_data;
  int                        mismatches;
  int                        outstanding;
  int                        cycle_count = 0;
  int                        items_sent  = 0;
  int                        burst_left  = 0;

  // What the stimulus has written, so that search keys can be picked from the array.
  logic signed [jse_pkg::DataW-1:0] shadow_store [jse_pkg::MaxElements];

  jse_item_if   item_bus ();
  jse_result_if result_bus ();

  jump_search_engine dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .item_i     (item_bus),
    .result_o   (result_bus)
  );

  search_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_data_i    (cfg_data),
    .item_i        (item_bus),
    .result_i      (result_bus),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("[jump_search_engine] ERROR");
      $finish;
    end
  end

  // Receiver: each stretch picks a stall pattern, from always ready down to rare acceptance.
  initial begin
    int pattern;
    int stretch;
    result_bus.ready = 1'b0;
    pattern          = 0;
    stretch          = 0;
    forever begin
      @(posedge clk_i);
      if (stretch == 0) begin
        pattern = $urandom_range(0, 3);
        stretch = $urandom_range(20, 300);
      end
      stretch--;
      case (pattern)
        0: begin
          result_bus.ready <= 1'b1;
        end
        1: begin
          result_bus.ready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          result_bus.ready <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          result_bus.ready <= ($urandom_range(0, 15) == 0);
        end
      endcase
    end
  end

  // One transfer on the item channel. The task is entered and left in the time step of a
  // rising edge; valid is left high so that a following burst item goes out back to back.
  task automatic send_item(input logic op, input logic [jse_pkg::IdxW-1:0] idx,
                           input logic signed [jse_pkg::DataW-1:0] value,
                           input logic signed [jse_pkg::DataW-1:0] key);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    item_bus.valid         <= 1'b1;
    item_bus.operation     <= op;
    item_bus.write_index   <= idx;
    item_bus.element_value <= value;
    item_bus.search_key    <= key;
    @(posedge clk_i);
    while (!item_bus.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
    if (op == jse_pkg::OpWrite) shadow_store[idx] = value;
  endtask

  // The unused fields of each item carry random values so that they are seen to be ignored.
  task automatic write_entry(input int idx, input logic signed [jse_pkg::DataW-1:0] value);
    send_item(jse_pkg::OpWrite, idx[jse_pkg::IdxW-1:0], value, $urandom);
  endtask

  task automatic search_key(input logic signed [jse_pkg::DataW-1:0] key);
    send_item(jse_pkg::OpSearch, jse_pkg::IdxW'($urandom_range(0, jse_pkg::MaxElements - 1)),
              $urandom, key);
  endtask

  // Stops sending until every search has come back and the block has finished any write.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (WriteSettle) @(posedge clk_i);
  endtask

  task automatic set_array_size(input int size);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_data <= size[jse_pkg::SizeW-1:0];
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  // Writes entries 0 to n-1 in index order. Clustered fills draw from a narrow range so that
  // runs of equal values appear; shuffled fills are left unsorted.
  task automatic load_array(input int n, input fill_e fill);
    logic signed [jse_pkg::DataW-1:0] vals [jse_pkg::MaxElements];
    logic signed [jse_pkg::DataW-1:0] held;
    logic signed [jse_pkg::DataW-1:0] base;
    int                               j;
    base = $urandom;
    for (int i = 0; i < n; i++) begin
      if (fill == FillClustered) vals[i] = base + $urandom_range(0, n / 2 + 1);
      else vals[i] = $urandom;
    end
    if (fill != FillShuffled) begin
      for (int i = 1; i < n; i++) begin
        held = vals[i];
        j    = i;
        while (j > 0 && vals[j-1] > held) begin
          vals[j] = vals[j-1];
          j--;
        end
        vals[j] = held;
      end
    end
    for (int i = 0; i < n; i++) write_entry(i, vals[i]);
    // Writes past the end of the array must not disturb searches within it.
    if (n < jse_pkg::MaxElements && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3))
        write_entry($urandom_range(n, jse_pkg::MaxElements - 1), $urandom);
    end
  endtask

  function automatic logic signed [jse_pkg::DataW-1:0] pick_key(input int n);
    int sel;
    int at;
    sel = $urandom_range(0, 99);
    if (n == 0 || sel < 10) return $urandom;
    at = $urandom_range(0, n - 1);
    if (sel < 60) return shadow_store[at];
    if (sel < 75) return shadow_store[at] + 1;
    if (sel < 85) return shadow_store[at] - 1;
    if (sel < 90) return KeyMin;
    if (sel < 95) return KeyMax;
    return shadow_store[n-1] + 1;
  endfunction

  // Searches over the first n entries; now and then the sender waits for every result first.
  task automatic run_searches(input int n, input int count);
    repeat (count) begin
      if ($urandom_range(0, 24) == 0) drain_results();
      search_key(pick_key(n));
    end
  endtask

  initial begin
    int    size;
    int    n;
    int    sel;
    fill_e fill;
    cfg_we                 = 1'b0;
    cfg_data               = '0;
    item_bus.valid         = 1'b0;
    item_bus.operation     = jse_pkg::OpWrite;
    item_bus.write_index   = '0;
    item_bus.element_value = '0;
    item_bus.search_key    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed stage. An empty array never finds anything.
    set_array_size(0);
    search_key(0);
    search_key(KeyMin);
    write_entry(jse_pkg::MaxElements - 1, KeyMax);
    // A single element at the bottom of the range; the top of the range lies beyond it.
    set_array_size(1);
    write_entry(0, KeyMin);
    search_key(KeyMin);
    search_key(KeyMax);
    search_key(0);
    // Both extremes in the array, and a key that falls between them.
    set_array_size(2);
    write_entry(1, KeyMax);
    search_key(KeyMax);
    search_key(KeyMin);
    search_key(-1);
    // A duplicated value must report its first occurrence.
    write_entry(0, -5);
    write_entry(1, 0);
    write_entry(2, 0);
    write_entry(3, 7);
    set_array_size(4);
    search_key(0);
    search_key(7);
    search_key(8);
    search_key(-6);

    // Full store, then sizes above capacity, which the block treats as a full store.
    set_array_size(jse_pkg::MaxElements);
    load_array(jse_pkg::MaxElements, FillSpread);
    run_searches(jse_pkg::MaxElements, 30);
    set_array_size((1 << jse_pkg::SizeW) - 1);
    run_searches(jse_pkg::MaxElements, 12);
    set_array_size($urandom_range(jse_pkg::MaxElements + 1, (1 << jse_pkg::SizeW) - 2));
    run_searches(jse_pkg::MaxElements, 8);

    // Random stage: mostly small arrays, which keep searches short.
    while (items_sent < TotalItems) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) size = 0;
      else if (sel < 11) size = $urandom_range(jse_pkg::MaxElements + 1,
                                               (1 << jse_pkg::SizeW) - 1);
      else if (sel < 16) size = $urandom_range(65, 400);
      else size = $urandom_range(1, 64);
      n = (size > jse_pkg::MaxElements) ? jse_pkg::MaxElements : size;
      set_array_size(size);
      if (size > 0 && size <= jse_pkg::MaxElements) begin
        sel = $urandom_range(0, 9);
        if (sel < 7) fill = FillSpread;
        else if (sel < 9) fill = FillClustered;
        else fill = FillShuffled;
        load_array(n, fill);
      end
      run_searches(n, (size == 0) ? $urandom_range(1, 4) : $urandom_range(4, 24));
    end

    // Let everything come back, then allow one more search time for anything stray.
    item_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SearchLatency) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[jump_search_engine] OK");
    end else begin
      $display("[jump_search_engine] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/jse_pkg.sv
hw/rtl/jse_item_if.sv
hw/rtl/jse_result_if.sv
hw/rtl/jse_store.sv
hw/rtl/jse_isqrt.sv
hw/rtl/jump_search_engine.sv
test/search_result_checker.sv
test/tb.sv
